### hdl/mcpg_pkg.sv
// Shared types, codes and constants of the multi-channel PWM generator.
`timescale 1ns / 1ps
package mcpg_pkg;

   // Default table depth
   localparam int CHANNELS_DEF = 8;

   // Field widths
   localparam int PIN_W    = 8;
   localparam int FREQ_W   = 16;
   localparam int DUTY_W   = 11;
   localparam int PERIOD_W = 20;
   localparam int TIME_W   = 32;

   // Divider: fixed dividend, one quotient bit a step
   localparam int                  QUOT_W   = PERIOD_W;
   localparam int                  STEP_W   = $clog2(QUOT_W + 1);
   localparam logic [QUOT_W-1:0]   US_PER_S = QUOT_W'(1000000);

   // Full-scale duty
   localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(1024);

   // Command codes
   localparam logic [2:0] MODE_TICK = 3'd0;
   localparam logic [2:0] MODE_ADD  = 3'd1;
   localparam logic [2:0] MODE_FREQ = 3'd2;
   localparam logic [2:0] MODE_DUTY = 3'd3;
   localparam logic [2:0] MODE_ON   = 3'd4;
   localparam logic [2:0] MODE_OFF  = 3'd5;

   // Unused command codes, ignored by the block
   localparam logic [2:0] MODE_SPARE_A = 3'd6;
   localparam logic [2:0] MODE_SPARE_B = 3'd7;

   // Result kinds
   localparam logic [1:0] KIND_LEVEL    = 2'd0;
   localparam logic [1:0] KIND_ADD_OK   = 2'd1;
   localparam logic [1:0] KIND_ADD_FULL = 2'd2;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_MUL,
      ST_WRITE,
      ST_SCAN,
      ST_EVAL
   } state_type;

   // One channel table entry
   typedef struct packed {
      logic [PIN_W-1:0]    pin;
      logic [FREQ_W-1:0]   freq;
      logic [DUTY_W-1:0]   duty;
      logic [PERIOD_W-1:0] period;
      logic [PERIOD_W-1:0] high;
      logic [TIME_W-1:0]   start;
   } chan_rec_type;

   // Duty saturates at full scale
   function automatic logic [DUTY_W-1:0] sat_duty(input logic [DUTY_W-1:0] d);
      return (d > DUTY_FULL) ? DUTY_FULL : d;
   endfunction

endpackage

### hdl/mcpg_div.sv
// Restoring divider: 1000000 / divisor, one quotient bit per cycle.
`timescale 1ns / 1ps
module mcpg_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [mcpg_pkg::FREQ_W-1:0]          divisor,
   output logic                                 done,
   output logic [mcpg_pkg::QUOT_W-1:0]          quotient
);

   logic                              active_ff, active_in;
   logic                              done_ff, done_in;
   logic [mcpg_pkg::STEP_W-1:0]       cnt_ff, cnt_in;
   logic [mcpg_pkg::FREQ_W-1:0]       rem_ff, rem_in;
   logic [mcpg_pkg::FREQ_W-1:0]       dsr_ff, dsr_in;
   logic [mcpg_pkg::QUOT_W-1:0]       dvd_ff, dvd_in;
   logic [mcpg_pkg::QUOT_W-1:0]       quot_ff, quot_in;
   logic [mcpg_pkg::FREQ_W:0]         shifted;
   logic [mcpg_pkg::FREQ_W:0]         diff;
   logic                              fits;

   // One trial subtraction
   assign shifted = {rem_ff, dvd_ff[mcpg_pkg::QUOT_W-1]};
   assign diff    = shifted - {1'b0, dsr_ff};
   assign fits    = (shifted >= {1'b0, dsr_ff});

   // Step control
   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      dsr_in    = dsr_ff;
      dvd_in    = dvd_ff;
      quot_in   = quot_ff;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = mcpg_pkg::STEP_W'(mcpg_pkg::QUOT_W);
         rem_in    = '0;
         dsr_in    = divisor;
         dvd_in    = mcpg_pkg::US_PER_S;
         quot_in   = '0;
      end else if (active_ff) begin
         rem_in  = fits ? diff[mcpg_pkg::FREQ_W-1:0] : shifted[mcpg_pkg::FREQ_W-1:0];
         quot_in = {quot_ff[mcpg_pkg::QUOT_W-2:0], fits};
         dvd_in  = {dvd_ff[mcpg_pkg::QUOT_W-2:0], 1'b0};
         cnt_in  = cnt_ff - mcpg_pkg::STEP_W'(1);
         if (cnt_ff == mcpg_pkg::STEP_W'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      dvd_ff  <= dvd_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

### hdl/mcpg_table.sv
// Channel table memory: one write port, one registered read port.
`timescale 1ns / 1ps
module mcpg_table #(
   parameter int CHANNELS = mcpg_pkg::CHANNELS_DEF,
   parameter int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [IDX_W-1:0]             wr_addr,
   input  mcpg_pkg::chan_rec_type       wr_data,
   input  logic [IDX_W-1:0]             rd_addr,
   output mcpg_pkg::chan_rec_type       rd_data
);

   mcpg_pkg::chan_rec_type mem_ff [CHANNELS];
   mcpg_pkg::chan_rec_type rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/multi_channel_pwm_generator.sv
// Multi-channel PWM generator: command sequencer over a channel table and a shared divider.
// Enable, disable, spare codes and a refused add stay idle. Add runs DIV, MUL, WRITE (WRITE if zero
// frequency), set-frequency LOAD, DIV, MUL, WRITE, set-duty LOAD, MUL, WRITE (LOAD, WRITE if zero).
// Tick: SCAN, EVAL per enabled channel; SCAN per skipped index below the last enabled; final SCAN.
// Each result is registered onto the rsp_ ports in the cycle after it is formed; the receiver cannot stall.
// Reset clears the sequencer, channel count and enable flags; table entries are kept.
`timescale 1ns / 1ps
module multi_channel_pwm_generator #(
   parameter int CHANNELS = mcpg_pkg::CHANNELS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [2:0]                       req_mode,
   input  logic [2:0]                       req_channel,
   input  logic [mcpg_pkg::PIN_W-1:0]       req_pin,
   input  logic [mcpg_pkg::FREQ_W-1:0]      req_freq,
   input  logic [mcpg_pkg::DUTY_W-1:0]      req_duty,
   input  logic [mcpg_pkg::TIME_W-1:0]      req_now,
   output logic                             rsp_valid,
   output logic [1:0]                       rsp_kind,
   output logic [2:0]                       rsp_channel_res,
   output logic [mcpg_pkg::PIN_W-1:0]       rsp_pin_res,
   output logic                             rsp_level,
   output logic                             rsp_last
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CNT_W = $clog2(CHANNELS + 1);

   mcpg_pkg::state_type               state_ff, state_in;
   mcpg_pkg::chan_rec_type            work_ff, work_in;
   logic [IDX_W-1:0]                  addr_ff, addr_in;
   logic [2:0]                        mode_ff, mode_in;
   logic [mcpg_pkg::TIME_W-1:0]       now_ff, now_in;
   logic [mcpg_pkg::FREQ_W-1:0]       arg_freq_ff, arg_freq_in;
   logic [mcpg_pkg::DUTY_W-1:0]       arg_duty_ff, arg_duty_in;
   logic [CHANNELS-1:0]               pending_ff, pending_in;
   logic [CHANNELS-1:0]               on_ff, on_in;
   logic [CNT_W-1:0]                  count_ff, count_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [1:0]                        rsp_kind_ff, rsp_kind_in;
   logic [2:0]                        rsp_chan_ff, rsp_chan_in;
   logic [mcpg_pkg::PIN_W-1:0]        rsp_pin_ff, rsp_pin_in;
   logic                              rsp_level_ff, rsp_level_in;
   logic                              rsp_last_ff, rsp_last_in;

   logic                              div_start;
   logic                              div_done;
   logic [mcpg_pkg::QUOT_W-1:0]       div_quot;
   logic                              wr_en;
   mcpg_pkg::chan_rec_type            wr_data;
   logic [IDX_W-1:0]                  rd_addr;
   mcpg_pkg::chan_rec_type            rd_data;

   // Shared divider
   mcpg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (work_in.freq),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Channel table
   mcpg_table #(
      .CHANNELS (CHANNELS),
      .IDX_W    (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Sequencer: next state and datapath
   always_comb begin
      mcpg_pkg::chan_rec_type       rec;
      logic [29:0]                  prod;
      logic [mcpg_pkg::TIME_W-1:0]  elapsed;
      logic [CHANNELS-1:0]          sel_bit;
      logic                         claimed;

      rec      = rd_data;
      prod     = 30'(work_ff.duty) * 30'(work_ff.period);
      elapsed  = now_ff - rd_data.start;
      sel_bit  = CHANNELS'(1) << addr_ff;
      claimed  = (32'(req_channel) < 32'(count_ff));

      state_in     = state_ff;
      work_in      = work_ff;
      addr_in      = addr_ff;
      mode_in      = mode_ff;
      now_in       = now_ff;
      arg_freq_in  = arg_freq_ff;
      arg_duty_in  = arg_duty_ff;
      pending_in   = pending_ff;
      on_in        = on_ff;
      count_in     = count_ff;
      div_start    = 1'b0;
      wr_en        = 1'b0;
      wr_data      = work_ff;
      rd_addr      = addr_ff;
      rsp_valid_in = 1'b0;
      rsp_kind_in  = mcpg_pkg::KIND_LEVEL;
      rsp_chan_in  = '0;
      rsp_pin_in   = '0;
      rsp_level_in = 1'b0;
      rsp_last_in  = 1'b0;

      case (state_ff)
         mcpg_pkg::ST_IDLE: begin
            rd_addr = IDX_W'(req_channel);
            if (start) begin
               mode_in     = req_mode;
               now_in      = req_now;
               arg_freq_in = req_freq;
               arg_duty_in = mcpg_pkg::sat_duty(req_duty);
               addr_in     = IDX_W'(req_channel);
               case (req_mode)
                  mcpg_pkg::MODE_TICK: begin
                     addr_in    = '0;
                     pending_in = on_ff;
                     state_in   = mcpg_pkg::ST_SCAN;
                  end
                  mcpg_pkg::MODE_ADD: begin
                     if (count_ff == CNT_W'(CHANNELS)) begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = mcpg_pkg::KIND_ADD_FULL;
                        rsp_last_in  = 1'b1;
                     end else begin
                        addr_in       = IDX_W'(count_ff);
                        work_in.pin   = req_pin;
                        work_in.freq  = req_freq;
                        work_in.duty  = mcpg_pkg::sat_duty(req_duty);
                        work_in.period = '0;
                        work_in.high  = '0;
                        work_in.start = req_now;
                        if (req_freq != '0) begin
                           div_start = 1'b1;
                           state_in  = mcpg_pkg::ST_DIV;
                        end else begin
                           state_in  = mcpg_pkg::ST_WRITE;
                        end
                     end
                  end
                  mcpg_pkg::MODE_FREQ, mcpg_pkg::MODE_DUTY: begin
                     if (claimed) begin
                        state_in = mcpg_pkg::ST_LOAD;
                     end
                  end
                  mcpg_pkg::MODE_ON: begin
                     if (claimed) begin
                        on_in[IDX_W'(req_channel)] = 1'b1;
                     end
                  end
                  mcpg_pkg::MODE_OFF: begin
                     if (claimed) begin
                        on_in[IDX_W'(req_channel)] = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Entry read back: merge the new frequency or duty
         mcpg_pkg::ST_LOAD: begin
            if (mode_ff == mcpg_pkg::MODE_FREQ) begin
               rec.freq = arg_freq_ff;
            end else begin
               rec.duty = arg_duty_ff;
            end
            work_in = rec;
            if (mode_ff == mcpg_pkg::MODE_FREQ && rec.freq != '0) begin
               div_start = 1'b1;
               state_in  = mcpg_pkg::ST_DIV;
            end else if (rec.freq == '0) begin
               work_in.high = '0;
               state_in     = mcpg_pkg::ST_WRITE;
            end else begin
               state_in = mcpg_pkg::ST_MUL;
            end
         end

         // Period from the divider
         mcpg_pkg::ST_DIV: begin
            if (div_done) begin
               work_in.period = div_quot;
               state_in       = mcpg_pkg::ST_MUL;
            end
         end

         // High time = duty * period / 1024
         mcpg_pkg::ST_MUL: begin
            work_in.high = prod[29:10];
            state_in     = mcpg_pkg::ST_WRITE;
         end

         mcpg_pkg::ST_WRITE: begin
            wr_en = 1'b1;
            if (mode_ff == mcpg_pkg::MODE_ADD) begin
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = mcpg_pkg::KIND_ADD_OK;
               rsp_chan_in    = 3'(addr_ff);
               rsp_pin_in     = work_ff.pin;
               rsp_last_in    = 1'b1;
               count_in       = count_ff + CNT_W'(1);
               on_in[addr_ff] = 1'b1;
            end
            state_in = mcpg_pkg::ST_IDLE;
         end

         // Tick walk: find the next enabled channel
         mcpg_pkg::ST_SCAN: begin
            if (pending_ff == '0) begin
               state_in = mcpg_pkg::ST_IDLE;
            end else if (pending_ff[addr_ff]) begin
               state_in = mcpg_pkg::ST_EVAL;
            end else begin
               addr_in = addr_ff + IDX_W'(1);
            end
         end

         // Report level, restart the cycle once the period has passed
         mcpg_pkg::ST_EVAL: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = mcpg_pkg::KIND_LEVEL;
            rsp_chan_in  = 3'(addr_ff);
            rsp_pin_in   = rd_data.pin;
            rsp_level_in = (elapsed <= {12'b0, rd_data.high});
            rsp_last_in  = ((pending_ff & ~sel_bit) == '0);
            if (elapsed > {12'b0, rd_data.period}) begin
               wr_en         = 1'b1;
               wr_data       = rd_data;
               wr_data.start = now_ff;
            end
            pending_in = pending_ff & ~sel_bit;
            addr_in    = addr_ff + IDX_W'(1);
            state_in   = mcpg_pkg::ST_SCAN;
         end

         default: begin
            state_in = mcpg_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mcpg_pkg::ST_IDLE;
         count_ff     <= '0;
         on_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         on_ff        <= on_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and result registers
   always_ff @(posedge clock) begin
      work_ff      <= work_in;
      addr_ff      <= addr_in;
      mode_ff      <= mode_in;
      now_ff       <= now_in;
      arg_freq_ff  <= arg_freq_in;
      arg_duty_ff  <= arg_duty_in;
      pending_ff   <= pending_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_chan_ff  <= rsp_chan_in;
      rsp_pin_ff   <= rsp_pin_in;
      rsp_level_ff <= rsp_level_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign busy            = (state_ff != mcpg_pkg::ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_channel_res = rsp_chan_ff;
   assign rsp_pin_res     = rsp_pin_ff;
   assign rsp_level       = rsp_level_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

### hdl/mcpg_checker.sv
// Port-level checks for the multi-channel PWM generator, bound to the top level.
`timescale 1ns / 1ps
module mcpg_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic [2:0]                       req_mode,
   input logic                             rsp_valid,
   input logic [1:0]                       rsp_kind,
   input logic [2:0]                       rsp_channel_res,
   input logic [mcpg_pkg::PIN_W-1:0]       rsp_pin_res,
   input logic                             rsp_level,
   input logic                             rsp_last
);

   // Reset leaves the block idle with no transfer pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_valid))
      else $error("block not idle after reset");

   // Add results are single and carry a low level
   a_add_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != mcpg_pkg::KIND_LEVEL) |-> (rsp_last && !rsp_level))
      else $error("add result not single or level set");

   // A refused add names no channel and no pin
   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == mcpg_pkg::KIND_ADD_FULL)
      |-> (rsp_channel_res == '0 && rsp_pin_res == '0))
      else $error("refused add carries channel or pin");

   // Enable, disable and unused codes give no result
   a_silent_cmd: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_mode == mcpg_pkg::MODE_ON || req_mode == mcpg_pkg::MODE_OFF
         || req_mode == mcpg_pkg::MODE_SPARE_A || req_mode == mcpg_pkg::MODE_SPARE_B))
      |=> !rsp_valid)
      else $error("result after a command that gives none");

endmodule

bind multi_channel_pwm_generator mcpg_checker u_mcpg_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_mode        (req_mode),
   .rsp_valid       (rsp_valid),
   .rsp_kind        (rsp_kind),
   .rsp_channel_res (rsp_channel_res),
   .rsp_pin_res     (rsp_pin_res),
   .rsp_level       (rsp_level),
   .rsp_last        (rsp_last)
);
